// File: design/gaussian_blur_5x5_rgb_macros.svh
// ----------------------------------------------------------------------------
// gaussian blur assertion macros
// shared clocked assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_5X5_RGB_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_RGB_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define GB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds at the clock edge after the antecedent
`define GB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define GB_ASSERT(lbl, cond, msg)

`define GB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/gb_pkg.sv
// ----------------------------------------------------------------------------
// gb_pkg
// types and constants of the 5x5 gaussian blur
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gb_pkg;

  localparam int NTAP       = 5;
  localparam int NCH        = 3;
  localparam int PIX_W      = 8;
  localparam int WT_W       = 6;
  localparam int CSUM_W     = 15;
  localparam int TSUM_W     = 17;
  localparam int RECIP_W    = 17;
  localparam int DIV_SHIFT  = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // floor(x / 273) == (x * DIV_RECIP) >> DIV_SHIFT for x below 123941
  localparam logic [RECIP_W-1:0] DIV_RECIP = 17'd122911;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // channel 0 blue, 1 green, 2 red
  typedef logic [NCH-1:0][PIX_W-1:0] pix_t;
  typedef pix_t [NTAP-1:0]           col_t;
  typedef pix_t [NTAP-2:0]           lb_word_t;
  typedef logic [WT_W-1:0]           wt_t;
  typedef wt_t [NTAP-1:0]            wcol_t;
  typedef logic [CSUM_W-1:0]         csum_t;
  typedef csum_t [NCH-1:0]           csum3_t;
  typedef logic [TSUM_W-1:0]         tsum_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    logic [NTAP-1:0] mask;
  } side_t;

  localparam wcol_t KERN [NTAP] = '{
    {6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    {6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    {6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    {6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    {6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

endpackage

// File: design/gb_line_buf.sv
// ----------------------------------------------------------------------------
// gb_line_buf
// four stacked line delays in one memory word, registered read with bypass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gb_line_buf import gb_pkg::*; #(
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  lb_word_t      wr_data,
  input  logic [AW-1:0] rd_addr,
  output lb_word_t      rd_data
);

  lb_word_t mem [DEPTH];
  lb_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/gb_cell.sv
// ----------------------------------------------------------------------------
// gb_cell
// one window column: holds five pixels, passes them on, forms the column sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gb_cell import gb_pkg::*; (
  input  logic   clk,
  input  logic   shift_en,
  input  logic   pipe_en,
  input  wcol_t  wt,
  input  col_t   col_in,
  output col_t   col_out,
  output csum3_t csum
);

  col_t   col_r;
  csum3_t csum_r;
  csum3_t csum_nxt;

  always_comb begin
    csum_t acc;
    for (int ch = 0; ch < NCH; ch++) begin
      acc = '0;
      for (int k = 0; k < NTAP; k++) begin
        acc = acc + CSUM_W'(col_r[k][ch]) * CSUM_W'(wt[k]);
      end
      csum_nxt[ch] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
    if (pipe_en) begin
      csum_r <= csum_nxt;
    end
  end

  assign col_out = col_r;
  assign csum    = csum_r;

endmodule

// File: design/gb_sum_div.sv
// ----------------------------------------------------------------------------
// gb_sum_div
// masked sum of the column sums, then divide by 273 into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gb_sum_div import gb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   pipe_en,
  input  side_t  a_side,
  input  csum3_t csum [NTAP],
  output logic   out_valid,
  output logic   out_last,
  output pix_t   blur
);

  localparam int PROD_W = TSUM_W + RECIP_W;

  side_t b_side_r;
  logic  c_valid_r;
  logic  c_last_r;
  tsum_t c_sum_r [NCH];
  tsum_t c_sum_nxt [NCH];
  logic  d_valid_r;
  logic  d_last_r;
  pix_t  d_blur_r;
  pix_t  d_blur_nxt;

  always_comb begin
    tsum_t acc;
    for (int ch = 0; ch < NCH; ch++) begin
      acc = '0;
      for (int j = 0; j < NTAP; j++) begin
        if (b_side_r.mask[j]) begin
          acc = acc + TSUM_W'(csum[j][ch]);
        end
      end
      c_sum_nxt[ch] = acc;
    end
  end

  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int ch = 0; ch < NCH; ch++) begin
      prod = PROD_W'(c_sum_r[ch]) * PROD_W'(DIV_RECIP);
      d_blur_nxt[ch] = prod[DIV_SHIFT +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_side_r.valid <= 1'b0;
      c_valid_r      <= 1'b0;
      d_valid_r      <= 1'b0;
    end else if (pipe_en) begin
      b_side_r.valid <= a_side.valid;
      c_valid_r      <= b_side_r.valid;
      d_valid_r      <= c_valid_r;
    end
    if (pipe_en) begin
      b_side_r.last <= a_side.last;
      b_side_r.mask <= a_side.mask;
      c_last_r      <= b_side_r.last;
      c_sum_r       <= c_sum_nxt;
      d_last_r      <= c_last_r;
      d_blur_r      <= d_blur_nxt;
    end
  end

  assign out_valid = d_valid_r;
  assign out_last  = d_last_r;
  assign blur      = d_blur_r;

endmodule

// File: design/gaussian_blur_5x5_rgb.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb
// streamed 5x5 gaussian blur of rgb pixels, zero outside the frame
// ----------------------------------------------------------------------------
// in_*  : one pixel item per beat in raster order; in_tuser high marks a
//         drain item, sent after the frame to flush the remaining outputs.
//         a pixel beyond the frame counts as a drain item; a drain item
//         before the frame is complete is taken and dropped.
// out_* : blurred pixel items in raster order; out_tlast on the last one of
//         the frame, after which the next pixel item starts a new frame.
// cfg_* : width (index 0) and height (index 1), written while idle; a write
//         restarts the frame. zero acts as one, oversize as the maximum.
// throughput: one item per clock while out_* is not stalled, set by the window column cells
//   and the simple dual-port line memory doing one read and one write per item.
// output: the output for pixel p comes with input item p + 2*width + 2 and
//   passes through the column sum, masked sum and divide registers to out_*.
// a stall on out_tready freezes the whole pipe and drops in_tready.
// reset: width and height return to 1024 (capped at the maxima) and the
//   frame restarts; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gaussian_blur_5x5_rgb_macros.svh"

module gaussian_blur_5x5_rgb import gb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // pixel_blue, pixel_green, pixel_red
  input  logic                  in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // blur_blue, blur_green, blur_red
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 4);
  localparam int RXW   = RW + 1;
  localparam int PW    = $clog2(2 * MAX_WIDTH + 3);
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  logic [WW-1:0] eff_w_r, eff_w_nxt;
  logic [HW-1:0] eff_h_r, eff_h_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [PW-1:0] prime_r, prime_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;
  side_t         a_side_r, a_side_nxt;

  logic          adv;
  logic          acc;
  logic          pix_done;
  logic          step;
  logic          fire;
  logic          last;
  logic          col_end;
  logic          out_col_end;
  logic          out_row_end;
  logic          cfg_hit;
  logic [PW-1:0] lag;

  pix_t          new_pix;
  lb_word_t      lb_rdata;
  lb_word_t      lb_wdata;
  col_t          taps;
  col_t          entry_col;
  col_t          chain [NTAP];
  csum3_t        csum [NTAP];

  logic          blur_valid;
  logic          blur_last;
  pix_t          blur;

  assign adv       = !blur_valid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid && adv;
  assign pix_done  = (RXW'(in_row_r) >= RXW'(eff_h_r));
  assign step      = acc && (pix_done || !in_tuser);
  assign lag       = PW'({eff_w_r, 1'b0}) + PW'(2);
  assign fire      = step && (prime_r == lag);

  assign col_end     = (WW'(in_col_r) == (eff_w_r - WW'(1)));
  assign out_col_end = (WW'(out_col_r) == (eff_w_r - WW'(1)));
  assign out_row_end = (out_row_r == (eff_h_r - HW'(1)));
  assign last        = fire && out_col_end && out_row_end;
  assign cfg_hit     = cfg_valid && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

  // geometry registers hold the clamped size
  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (cfg_valid && (cfg_index == CFG_WIDTH)) begin
      if (cfg_data == '0) begin
        eff_w_nxt = WW'(1);
      end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
        eff_w_nxt = WW'(MAX_WIDTH);
      end else begin
        eff_w_nxt = WW'(cfg_data);
      end
    end
    if (cfg_valid && (cfg_index == CFG_HEIGHT)) begin
      if (cfg_data == '0) begin
        eff_h_nxt = HW'(1);
      end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
        eff_h_nxt = HW'(MAX_HEIGHT);
      end else begin
        eff_h_nxt = HW'(cfg_data);
      end
    end
  end

  // raster position of the stream and of the output pixel
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    prime_nxt   = prime_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (step) begin
      if (col_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (prime_r != lag) begin
        prime_nxt = prime_r + PW'(1);
      end
    end
    if (fire) begin
      if (out_col_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + HW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
    if (last || cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      prime_nxt   = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  // new column: row-masked pixel and line taps
  assign new_pix = pix_t'(in_tdata);

  always_comb begin
    taps[0]     = new_pix;
    lb_wdata[0] = new_pix;
    for (int k = 1; k < NTAP; k++) begin
      taps[k] = lb_rdata[k-1];
    end
    for (int k = 1; k < NTAP - 1; k++) begin
      lb_wdata[k] = lb_rdata[k-1];
    end
    for (int k = 0; k < NTAP; k++) begin
      if ((RXW'(in_row_r) >= RXW'(k)) &&
          (RXW'(in_row_r) < (RXW'(eff_h_r) + RXW'(k)))) begin
        entry_col[k] = taps[k];
      end else begin
        entry_col[k] = '0;
      end
    end
  end

  // column mask of the output pixel, cell 0 holds the newest column
  always_comb begin
    a_side_nxt.valid   = fire;
    a_side_nxt.last    = last;
    a_side_nxt.mask[0] = ((WW + 1)'(out_col_r) + (WW + 1)'(2)) < (WW + 1)'(eff_w_r);
    a_side_nxt.mask[1] = ((WW + 1)'(out_col_r) + (WW + 1)'(1)) < (WW + 1)'(eff_w_r);
    a_side_nxt.mask[2] = 1'b1;
    a_side_nxt.mask[3] = (out_col_r != '0);
    a_side_nxt.mask[4] = (out_col_r >= CW'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r        <= WW'(RST_W);
      eff_h_r        <= HW'(RST_H);
      in_col_r       <= '0;
      in_row_r       <= '0;
      prime_r        <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      a_side_r.valid <= 1'b0;
    end else begin
      eff_w_r   <= eff_w_nxt;
      eff_h_r   <= eff_h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      prime_r   <= prime_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (adv) begin
        a_side_r.valid <= a_side_nxt.valid;
      end
    end
    if (adv) begin
      a_side_r.last <= a_side_nxt.last;
      a_side_r.mask <= a_side_nxt.mask;
    end
  end

  gb_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (step),
    .wr_addr (in_col_r),
    .wr_data (lb_wdata),
    .rd_addr (in_col_nxt),
    .rd_data (lb_rdata)
  );

  assign chain[0] = entry_col;

  for (genvar j = 0; j < NTAP; j++) begin : g_cell
    if (j < NTAP - 1) begin : g_mid
      gb_cell u_cell (
        .clk      (clk),
        .shift_en (step),
        .pipe_en  (adv),
        .wt       (KERN[j]),
        .col_in   (chain[j]),
        .col_out  (chain[j+1]),
        .csum     (csum[j])
      );
    end else begin : g_end
      gb_cell u_cell (
        .clk      (clk),
        .shift_en (step),
        .pipe_en  (adv),
        .wt       (KERN[j]),
        .col_in   (chain[j]),
        .col_out  (),
        .csum     (csum[j])
      );
    end
  end

  gb_sum_div u_sum_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe_en   (adv),
    .a_side    (a_side_r),
    .csum      (csum),
    .out_valid (blur_valid),
    .out_last  (blur_last),
    .blur      (blur)
  );

  assign out_tvalid = blur_valid;
  assign out_tlast  = blur_last;
  assign out_tdata  = 24'(blur);

  `GB_ASSERT(a_col_range, in_col_r < eff_w_r, "input column beyond frame width")
  `GB_ASSERT(a_orow_range, out_row_r < eff_h_r, "output row beyond frame height")
  `GB_ASSERT(a_prime_range, prime_r <= lag, "priming count beyond window lag")
  `GB_ASSERT_NEXT(a_frame_clear, last, (in_row_r == '0) && (prime_r == '0) && (out_col_r == '0), "counters not cleared after frame end")

endmodule
